// ----- rtl/gbn_pkg.sv -----
// ----------------------------------------------------------------------------
// gbn_pkg
// shared types and constants of the go-back-n sender window
// ----------------------------------------------------------------------------
package gbn_pkg;

	localparam int WIN_W       = 5;
	localparam int TICK_W      = 16;
	localparam int PCOUNT_W    = 16;
	localparam int PORT_SEQ_W  = 16;
	localparam int MAX_WINDOW  = 16;
	localparam int MAX_RESULTS = 16;
	localparam int WINC_W      = $clog2(MAX_WINDOW + 1);
	localparam int BURST_W     = $clog2(MAX_RESULTS + 1);
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [WIN_W-1:0]    WIN_RESET    = WIN_W'(5);
	localparam logic [TICK_W-1:0]   TICK_RESET   = TICK_W'(1000);
	localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = '0;

	typedef enum logic [1:0] {
		FUNC_OFFER = 2'd0,
		FUNC_ACK   = 2'd1,
		FUNC_TICK  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		K_SEND    = 3'd0,
		K_RETX    = 3'd1,
		K_REFUSED = 3'd2,
		K_ACK     = 3'd3,
		K_DROP    = 3'd4,
		K_IDLE    = 3'd5,
		K_DONE    = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		REG_WINDOW  = 2'd0,
		REG_TIMEOUT = 2'd1,
		REG_PCOUNT  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [WIN_W-1:0]    window;
		logic [TICK_W-1:0]   timeout;
		logic [PCOUNT_W-1:0] pcount;
	} cfg_t;

	// one decided step, expanded into results by the back end
	typedef struct packed {
		kind_t              kind;
		logic [BURST_W-1:0] count;
		logic               done_after;
		logic               timer_on;
	} job_t;

endpackage

// ----- rtl/gbn_regs.sv -----
// ----------------------------------------------------------------------------
// gbn_regs
// apb register file: window size, timeout ticks, packet count
// ----------------------------------------------------------------------------
module gbn_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gbn_pkg::ADDR_W-1:0] paddr,
	input  logic [gbn_pkg::DATA_W-1:0] pwdata,
	output logic [gbn_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output gbn_pkg::cfg_t              cfg
);
	import gbn_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window  <= WIN_RESET;
			cfg_q.timeout <= TICK_RESET;
			cfg_q.pcount  <= PCOUNT_RESET;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_WINDOW:  cfg_q.window  <= pwdata[WIN_W-1:0];
				REG_TIMEOUT: cfg_q.timeout <= pwdata[TICK_W-1:0];
				REG_PCOUNT:  cfg_q.pcount  <= pwdata[PCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WINDOW:  prdata = DATA_W'(cfg_q.window);
			REG_TIMEOUT: prdata = DATA_W'(cfg_q.timeout);
			REG_PCOUNT:  prdata = DATA_W'(cfg_q.pcount);
			default:     prdata = '0;
		endcase
	end

endmodule

// ----- rtl/gbn_front.sv -----
// ----------------------------------------------------------------------------
// gbn_front
// sequence and timer state; decides each request and queues one job for it
// ----------------------------------------------------------------------------
module gbn_front #(
	parameter int SEQ_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gbn_pkg::cfg_t                  cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     func,
	input  logic [gbn_pkg::PORT_SEQ_W-1:0] ack_seq,
	input  logic                           ack_corrupt,
	input  logic                           q_ready,
	output logic                           push,
	output gbn_pkg::job_t                  job,
	output logic [SEQ_BITS-1:0]            job_seq,
	output logic [SEQ_BITS-1:0]            job_base
);
	import gbn_pkg::*;

	localparam logic [SEQ_BITS-1:0] SEQ_ONE = SEQ_BITS'(1);

	logic [SEQ_BITS-1:0] next_q, base_q;
	logic [TICK_W-1:0]   tleft_q;
	logic                ton_q;

	logic [SEQ_BITS-1:0] n_next, n_base;
	logic [TICK_W-1:0]   n_tleft;
	logic                n_ton;

	logic [31:0]         ack_w, pc_w;
	logic [SEQ_BITS-1:0] ack_s, pc_s, outstanding, sent, adv, ack_nx;
	logic [WINC_W-1:0]   win_eff;
	logic [TICK_W-1:0]   tstart;
	logic                chk_done;

	assign ack_w       = 32'(ack_seq);
	assign ack_s       = ack_w[SEQ_BITS-1:0];
	assign pc_w        = 32'(cfg.pcount);
	assign pc_s        = pc_w[SEQ_BITS-1:0];
	assign outstanding = next_q - base_q;
	assign sent        = next_q - SEQ_ONE;
	assign ack_nx      = ack_s + SEQ_ONE;
	assign adv         = ack_nx - base_q;
	assign tstart      = (cfg.timeout == '0) ? TICK_W'(1) : cfg.timeout;

	assign in_ready = q_ready;
	assign push     = in_valid && q_ready;

	always_comb begin
		if (cfg.window == '0) begin
			win_eff = WINC_W'(1);
		end else if (32'(cfg.window) > 32'(MAX_WINDOW)) begin
			win_eff = WINC_W'(MAX_WINDOW);
		end else begin
			win_eff = WINC_W'(cfg.window);
		end
	end

	always_comb begin
		n_next         = next_q;
		n_base         = base_q;
		n_tleft        = tleft_q;
		n_ton          = ton_q;
		job.kind       = K_IDLE;
		job.count      = BURST_W'(1);
		job.done_after = 1'b0;
		job_seq        = '0;
		chk_done       = 1'b0;
		case (func_t'(func))
			FUNC_OFFER: begin
				chk_done = 1'b1;
				if (32'(outstanding) < 32'(win_eff) && 32'(sent) < pc_w) begin
					job.kind = K_SEND;
					job_seq  = next_q;
					if (base_q == next_q) begin
						n_tleft = tstart;
						n_ton   = 1'b1;
					end
					n_next = next_q + SEQ_ONE;
				end else begin
					job.kind = K_REFUSED;
				end
			end
			FUNC_ACK: begin
				chk_done = 1'b1;
				if (!ack_corrupt && adv <= outstanding) begin
					job.kind = K_ACK;
					n_base   = ack_nx;
					if (ack_nx == next_q) begin
						n_tleft = '0;
						n_ton   = 1'b0;
					end else begin
						n_tleft = tstart;
						n_ton   = 1'b1;
					end
				end else begin
					job.kind = K_DROP;
				end
			end
			FUNC_TICK: begin
				// completion takes the place of timer handling on a tick
				if (base_q - SEQ_ONE == pc_s) begin
					job.kind = K_DONE;
					n_base   = SEQ_ONE;
					n_next   = SEQ_ONE;
					n_tleft  = '0;
					n_ton    = 1'b0;
				end else if (!ton_q) begin
					job.kind = K_IDLE;
				end else if (tleft_q > TICK_W'(1)) begin
					job.kind = K_IDLE;
					n_tleft  = tleft_q - TICK_W'(1);
				end else if (outstanding == '0) begin
					job.kind = K_IDLE;
					n_tleft  = '0;
					n_ton    = 1'b0;
				end else begin
					job.kind = K_RETX;
					job_seq  = base_q;
					n_tleft  = tstart;
					n_ton    = 1'b1;
					if (32'(outstanding) > 32'(MAX_RESULTS)) begin
						job.count = BURST_W'(MAX_RESULTS);
					end else begin
						job.count = BURST_W'(outstanding);
					end
				end
			end
			default: begin
				job.kind = K_IDLE;
			end
		endcase
		if (chk_done && (n_base - SEQ_ONE) == pc_s) begin
			job.done_after = 1'b1;
			n_base         = SEQ_ONE;
			n_next         = SEQ_ONE;
			n_tleft        = '0;
			n_ton          = 1'b0;
		end
		job.timer_on = n_ton;
		job_base     = n_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q  <= SEQ_ONE;
			base_q  <= SEQ_ONE;
			tleft_q <= '0;
			ton_q   <= 1'b0;
		end else if (push) begin
			next_q  <= n_next;
			base_q  <= n_base;
			tleft_q <= n_tleft;
			ton_q   <= n_ton;
		end
	end

endmodule

// ----- rtl/gbn_fifo.sv -----
// ----------------------------------------------------------------------------
// gbn_fifo
// small job queue between the front and back ends
// ----------------------------------------------------------------------------
module gbn_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             not_empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata     = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/gbn_back.sv -----
// ----------------------------------------------------------------------------
// gbn_back
// expands queued jobs into registered results, one a cycle if out_ready allows
// ----------------------------------------------------------------------------
module gbn_back #(
	parameter int SEQ_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  gbn_pkg::job_t                  q_job,
	input  logic [SEQ_BITS-1:0]            q_seq,
	input  logic [SEQ_BITS-1:0]            q_base,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output gbn_pkg::kind_t                 kind,
	output logic [gbn_pkg::PORT_SEQ_W-1:0] seq,
	output logic                           last,
	output logic [gbn_pkg::PORT_SEQ_W-1:0] base_now,
	output logic                           timer_running
);
	import gbn_pkg::*;

	logic                act_q, done_q, ton_q;
	kind_t               kind_q;
	logic [SEQ_BITS-1:0] seq_q, base_q;
	logic [BURST_W-1:0]  rem_q;

	logic                  ovalid_q, olast_q, oton_q;
	kind_t                 okind_q;
	logic [PORT_SEQ_W-1:0] oseq_q, obase_q;

	logic                emit, e_last, main_left;
	kind_t               e_kind;
	logic [SEQ_BITS-1:0] e_seq;
	logic [31:0]         e_seq_w, base_w;

	assign main_left = (rem_q != '0);
	assign emit      = act_q && (!ovalid_q || out_ready);
	assign q_pop     = q_valid && (!act_q || (emit && e_last));
	assign e_seq_w   = 32'(e_seq);
	assign base_w    = 32'(base_q);

	// main results first, then the completion result if one is pending
	always_comb begin
		if (main_left) begin
			e_kind = kind_q;
			e_seq  = seq_q;
			e_last = (rem_q == BURST_W'(1)) && !done_q;
		end else begin
			e_kind = K_DONE;
			e_seq  = '0;
			e_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			done_q   <= 1'b0;
			rem_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (q_pop) begin
				act_q  <= 1'b1;
				rem_q  <= q_job.count;
				done_q <= q_job.done_after;
			end else if (emit) begin
				if (e_last) begin
					act_q <= 1'b0;
				end
				if (main_left) begin
					rem_q <= rem_q - BURST_W'(1);
				end else begin
					done_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			okind_q <= e_kind;
			oseq_q  <= e_seq_w[PORT_SEQ_W-1:0];
			olast_q <= e_last;
			obase_q <= base_w[PORT_SEQ_W-1:0];
			oton_q  <= ton_q;
		end
		if (q_pop) begin
			kind_q <= q_job.kind;
			seq_q  <= q_seq;
			base_q <= q_base;
			ton_q  <= q_job.timer_on;
		end else if (emit && main_left) begin
			seq_q <= seq_q + SEQ_BITS'(1);
		end
	end

	assign out_valid     = ovalid_q;
	assign kind          = okind_q;
	assign seq           = oseq_q;
	assign last          = olast_q;
	assign base_now      = obase_q;
	assign timer_running = oton_q;

endmodule

// ----- rtl/go_back_n_sender_window.sv -----
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// go-back-n sender control: window, sequence counters, retransmit timer
//
//   channel   signals                                   handshake
//   config    psel penable pwrite paddr pwdata prdata   apb, pready tied high
//   request   func ack_seq ack_corrupt                  in_valid / in_ready
//   result    kind seq last base_now timer_running      out_valid / out_ready
//
// a request is taken whenever the two-entry job queue has room. results
// leave at one per cycle while out_ready allows; a request causes 1 or 2
// results, up to 16 for a retransmission burst; the result expander in the
// back end emits them in order as it takes each job from the queue.
// reset is asynchronous; counters return to 1, timer stopped, registers to
// their reset values. out_ready low holds the result; the front keeps taking
// requests until the queue fills.
// ----------------------------------------------------------------------------
module go_back_n_sender_window #(
	parameter int SEQ_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gbn_pkg::ADDR_W-1:0]     paddr,
	input  logic [gbn_pkg::DATA_W-1:0]     pwdata,
	output logic [gbn_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     func,
	input  logic [gbn_pkg::PORT_SEQ_W-1:0] ack_seq,
	input  logic                           ack_corrupt,
	output logic                           out_valid,
	input  logic                           out_ready,
	output gbn_pkg::kind_t                 kind,
	output logic [gbn_pkg::PORT_SEQ_W-1:0] seq,
	output logic                           last,
	output logic [gbn_pkg::PORT_SEQ_W-1:0] base_now,
	output logic                           timer_running
);
	import gbn_pkg::*;

	localparam int JOB_W = $bits(job_t) + 2 * SEQ_BITS;

	cfg_t                cfg;
	job_t                f_job, b_job;
	logic [SEQ_BITS-1:0] f_seq, f_base, b_seq, b_base;
	logic                push, q_full, q_pop, q_valid;
	logic [JOB_W-1:0]    q_wdata, q_rdata;

	gbn_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gbn_front #(.SEQ_BITS(SEQ_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.ack_seq     (ack_seq),
		.ack_corrupt (ack_corrupt),
		.q_ready     (!q_full),
		.push        (push),
		.job         (f_job),
		.job_seq     (f_seq),
		.job_base    (f_base)
	);

	assign q_wdata = {f_job, f_seq, f_base};

	gbn_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.rdata     (q_rdata),
		.not_empty (q_valid)
	);

	assign {b_job, b_seq, b_base} = q_rdata;

	gbn_back #(.SEQ_BITS(SEQ_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_job         (b_job),
		.q_seq         (b_seq),
		.q_base        (b_base),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.seq           (seq),
		.last          (last),
		.base_now      (base_now),
		.timer_running (timer_running)
	);

endmodule
